### rtl/stu_pkg.sv
`timescale 1ns / 1ps

package stu_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int LINE_BITS   = 24;
  localparam int LENGTH_BITS = 16;
  localparam int KIND_BITS   = 5;

  // token kinds
  localparam logic [KIND_BITS-1:0] K_NUMBER = 5'd0;
  localparam logic [KIND_BITS-1:0] K_IDENT  = 5'd1;
  localparam logic [KIND_BITS-1:0] K_LET    = 5'd2;
  localparam logic [KIND_BITS-1:0] K_NULL   = 5'd3;
  localparam logic [KIND_BITS-1:0] K_PRINT  = 5'd4;
  localparam logic [KIND_BITS-1:0] K_IF     = 5'd5;
  localparam logic [KIND_BITS-1:0] K_TRUE   = 5'd6;
  localparam logic [KIND_BITS-1:0] K_FALSE  = 5'd7;
  localparam logic [KIND_BITS-1:0] K_ELSE   = 5'd8;
  localparam logic [KIND_BITS-1:0] K_WHILE  = 5'd9;
  localparam logic [KIND_BITS-1:0] K_FOR    = 5'd10;
  localparam logic [KIND_BITS-1:0] K_ASSIGN = 5'd11;
  localparam logic [KIND_BITS-1:0] K_EQ     = 5'd12;
  localparam logic [KIND_BITS-1:0] K_PLUS   = 5'd13;
  localparam logic [KIND_BITS-1:0] K_MINUS  = 5'd14;
  localparam logic [KIND_BITS-1:0] K_STAR   = 5'd15;
  localparam logic [KIND_BITS-1:0] K_SLASH  = 5'd16;
  localparam logic [KIND_BITS-1:0] K_SEMI   = 5'd17;
  localparam logic [KIND_BITS-1:0] K_LPAREN = 5'd18;
  localparam logic [KIND_BITS-1:0] K_RPAREN = 5'd19;
  localparam logic [KIND_BITS-1:0] K_LBRACE = 5'd20;
  localparam logic [KIND_BITS-1:0] K_RBRACE = 5'd21;
  localparam logic [KIND_BITS-1:0] K_BANG   = 5'd22;
  localparam logic [KIND_BITS-1:0] K_GT     = 5'd23;
  localparam logic [KIND_BITS-1:0] K_GE     = 5'd24;
  localparam logic [KIND_BITS-1:0] K_LT     = 5'd25;
  localparam logic [KIND_BITS-1:0] K_LE     = 5'd26;
  localparam logic [KIND_BITS-1:0] K_OROR   = 5'd27;
  localparam logic [KIND_BITS-1:0] K_ANDAND = 5'd28;
  localparam logic [KIND_BITS-1:0] K_EOF    = 5'd29;
  localparam logic [KIND_BITS-1:0] K_ERROR  = 5'd30;

  // tokens one source byte can raise
  localparam int MAX_RES  = 3;
  localparam int CNT_BITS = $clog2(MAX_RES + 1);

  // bundle queue depth, power of two
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [LINE_BITS-1:0]   line;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] len;
  } tok_t;

  // all tokens raised by one byte, slot 0 first
  typedef struct packed {
    logic [CNT_BITS-1:0]    cnt;
    tok_t [MAX_RES-1:0]     tok;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/stu_front.sv
`timescale 1ns / 1ps

module stu_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_char_byte,
  input  logic                in_end_of_source,
  input  stu_pkg::q_stat_t    q_stat,
  output logic                push,
  output stu_pkg::bundle_t    push_data
);
  import stu_pkg::*;

  typedef enum logic [6:0] {
    M_IDLE    = 7'b0000001,
    M_NUM     = 7'b0000010,
    M_WORD    = 7'b0000100,
    M_SYM     = 7'b0001000,
    M_COMMENT = 7'b0010000,
    M_ERROR   = 7'b0100000,
    M_DONE    = 7'b1000000
  } mode_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam int PREFIX_CHARS = 5;
  localparam int PREFIX_BITS  = 8 * PREFIX_CHARS;
  localparam int NUM_KW       = 9;

  // keyword text packed first byte highest
  localparam logic [PREFIX_BITS-1:0] KW_CODE [NUM_KW] = '{
    40'h000_06C6574, 40'h06E756C6C, 40'h7072696E74, 40'h0000006966, 40'h0074727565,
    40'h66616C7365,  40'h00656C7365, 40'h7768696C65, 40'h0000666F72
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd3, 3'd4, 3'd5, 3'd2, 3'd4, 3'd5, 3'd4, 3'd5, 3'd3
  };

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_wordch(input logic [7:0] c);
    return is_digit(c) || is_alpha(c) || (c == CH_USCORE);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CH_SPACE, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_held(input logic [7:0] c);
    return c inside {CH_EQ, CH_GT, CH_LT, CH_SLASH, CH_BAR, CH_AMP};
  endfunction

  function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] c);
    logic [KIND_BITS-1:0] k;
    case (c)
      CH_EQ:     k = K_ASSIGN;
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_STAR:   k = K_STAR;
      CH_SLASH:  k = K_SLASH;
      CH_SEMI:   k = K_SEMI;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_BANG:   k = K_BANG;
      CH_GT:     k = K_GT;
      CH_LT:     k = K_LT;
      default:   k = K_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_BITS-1:0] word_kind(input logic [PREFIX_BITS-1:0] prefix,
                                                     input logic [LENGTH_BITS-1:0] rlen);
    logic [KIND_BITS-1:0] k;
    k = K_IDENT;
    for (int i = 0; i < NUM_KW; i++) begin
      if (rlen == LENGTH_BITS'(KW_LEN[i]) && prefix == KW_CODE[i]) begin
        k = K_LET + KIND_BITS'(i);
      end
    end
    return k;
  endfunction

  function automatic tok_t mk_tok(input logic [KIND_BITS-1:0] kind,
                                  input logic [LINE_BITS-1:0] line,
                                  input logic [OFFSET_BITS-1:0] start,
                                  input logic [LENGTH_BITS-1:0] len);
    tok_t t;
    t.kind  = kind;
    t.line  = line;
    t.start = start;
    t.len   = len;
    return t;
  endfunction

  mode_t                   mode_r, mode_nxt;
  logic [7:0]              pend_r, pend_nxt;
  logic [PREFIX_BITS-1:0]  prefix_r, prefix_nxt;
  logic [LENGTH_BITS-1:0]  runlen_r, runlen_nxt;
  logic [OFFSET_BITS-1:0]  tstart_r, tstart_nxt;
  logic [OFFSET_BITS-1:0]  pos_r, pos_nxt;
  logic [LINE_BITS-1:0]    line_r, line_nxt;

  logic                    accept;
  logic                    last;
  logic [7:0]              c;
  logic                    used;
  logic [KIND_BITS-1:0]    k;
  logic [OFFSET_BITS-1:0]  pos_inc;
  logic [3:0]              tv;
  tok_t                    tk [4];
  logic [CNT_BITS-1:0]     cnt;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign c        = in_char_byte;
  assign last     = in_end_of_source;
  assign pos_inc  = (pos_r == '1) ? pos_r : pos_r + 1'b1;

  // tokens: 0 continuation or flush, 1 from idle, 2 flush on last, 3 end of file
  always_comb begin
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    prefix_nxt = prefix_r;
    runlen_nxt = runlen_r;
    tstart_nxt = tstart_r;
    pos_nxt    = pos_r;
    line_nxt   = line_r;
    used       = 1'b0;
    k          = K_ERROR;
    tv         = '0;
    for (int i = 0; i < 4; i++) begin
      tk[i] = '0;
    end

    if (mode_r == M_DONE) begin
      if (last) begin
        mode_nxt   = M_IDLE;
        pend_nxt   = '0;
        prefix_nxt = '0;
        runlen_nxt = '0;
        tstart_nxt = '0;
        pos_nxt    = '0;
        line_nxt   = LINE_BITS'(1);
      end
    end else if (mode_r == M_ERROR) begin
      if (last) begin
        tv[3]      = 1'b1;
        tk[3]      = mk_tok(K_EOF, line_r, pos_inc, '0);
        mode_nxt   = M_IDLE;
        pend_nxt   = '0;
        prefix_nxt = '0;
        runlen_nxt = '0;
        tstart_nxt = '0;
        pos_nxt    = '0;
        line_nxt   = LINE_BITS'(1);
      end
    end else begin
      case (mode_r)
        M_NUM: begin
          if (is_digit(c)) begin
            runlen_nxt = (runlen_r == '1) ? runlen_r : runlen_r + 1'b1;
            used       = 1'b1;
          end else begin
            tv[0]    = 1'b1;
            tk[0]    = mk_tok(K_NUMBER, line_r, tstart_r, runlen_r);
            mode_nxt = M_IDLE;
          end
        end
        M_WORD: begin
          if (is_wordch(c)) begin
            if (runlen_r < LENGTH_BITS'(PREFIX_CHARS)) begin
              prefix_nxt = {prefix_r[PREFIX_BITS-9:0], c};
            end
            runlen_nxt = (runlen_r == '1) ? runlen_r : runlen_r + 1'b1;
            used       = 1'b1;
          end else begin
            tv[0]    = 1'b1;
            tk[0]    = mk_tok(word_kind(prefix_r, runlen_r), line_r, tstart_r, runlen_r);
            mode_nxt = M_IDLE;
          end
        end
        M_SYM: begin
          if (pend_r == CH_SLASH && c == CH_SLASH) begin
            mode_nxt = M_COMMENT;
            used     = 1'b1;
          end else if (c == CH_EQ && (pend_r == CH_EQ || pend_r == CH_GT || pend_r == CH_LT)) begin
            tv[0]    = 1'b1;
            tk[0]    = mk_tok((pend_r == CH_EQ) ? K_EQ : ((pend_r == CH_GT) ? K_GE : K_LE),
                              line_r, tstart_r, LENGTH_BITS'(2));
            mode_nxt = M_IDLE;
            used     = 1'b1;
          end else if ((pend_r == CH_BAR || pend_r == CH_AMP) && c == pend_r) begin
            tv[0]    = 1'b1;
            tk[0]    = mk_tok((pend_r == CH_BAR) ? K_OROR : K_ANDAND,
                              line_r, tstart_r, LENGTH_BITS'(2));
            mode_nxt = M_IDLE;
            used     = 1'b1;
          end else begin
            k     = single_kind(pend_r);
            tv[0] = 1'b1;
            tk[0] = mk_tok(k, line_r, tstart_r, LENGTH_BITS'(1));
            if (k == K_ERROR) begin
              mode_nxt = M_ERROR;
              used     = 1'b1;
            end else begin
              mode_nxt = M_IDLE;
            end
          end
        end
        M_COMMENT: begin
          if (c == CH_NL || c == CH_NUL) begin
            mode_nxt = M_IDLE;
          end else begin
            used = 1'b1;
          end
        end
        default: ;
      endcase

      if (!used && mode_nxt == M_IDLE) begin
        if (c == CH_NUL) begin
          tv[1]    = 1'b1;
          tk[1]    = mk_tok(K_EOF, line_r, pos_r, '0);
          mode_nxt = M_DONE;
        end else if (is_digit(c)) begin
          mode_nxt   = M_NUM;
          tstart_nxt = pos_r;
          runlen_nxt = LENGTH_BITS'(1);
        end else if (is_alpha(c)) begin
          mode_nxt   = M_WORD;
          tstart_nxt = pos_r;
          runlen_nxt = LENGTH_BITS'(1);
          prefix_nxt = PREFIX_BITS'(c);
        end else if (is_space(c)) begin
          if (c == CH_NL) begin
            line_nxt = (line_r == '1) ? line_r : line_r + 1'b1;
          end
        end else if (is_held(c)) begin
          mode_nxt   = M_SYM;
          pend_nxt   = c;
          tstart_nxt = pos_r;
        end else begin
          k     = single_kind(c);
          tv[1] = 1'b1;
          tk[1] = mk_tok(k, line_r, pos_r, LENGTH_BITS'(1));
          if (k == K_ERROR) begin
            mode_nxt = M_ERROR;
          end
        end
      end

      pos_nxt = pos_inc;

      if (last) begin
        case (mode_nxt)
          M_NUM: begin
            tv[2] = 1'b1;
            tk[2] = mk_tok(K_NUMBER, line_nxt, tstart_nxt, runlen_nxt);
          end
          M_WORD: begin
            tv[2] = 1'b1;
            tk[2] = mk_tok(word_kind(prefix_nxt, runlen_nxt), line_nxt, tstart_nxt,
                           runlen_nxt);
          end
          M_SYM: begin
            tv[2] = 1'b1;
            tk[2] = mk_tok(single_kind(pend_nxt), line_nxt, tstart_nxt, LENGTH_BITS'(1));
          end
          default: ;
        endcase
        if (mode_nxt != M_DONE) begin
          tv[3] = 1'b1;
          tk[3] = mk_tok(K_EOF, line_nxt, pos_inc, '0);
        end
        mode_nxt   = M_IDLE;
        pend_nxt   = '0;
        prefix_nxt = '0;
        runlen_nxt = '0;
        tstart_nxt = '0;
        pos_nxt    = '0;
        line_nxt   = LINE_BITS'(1);
      end
    end
  end

  // pack raised tokens into consecutive slots
  always_comb begin
    cnt           = '0;
    push_data.tok = '0;
    for (int i = 0; i < 4; i++) begin
      if (tv[i] && cnt != CNT_BITS'(MAX_RES)) begin
        push_data.tok[cnt] = tk[i];
        cnt = cnt + 1'b1;
      end
    end
    push_data.cnt = cnt;
  end

  assign push = accept && (cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pend_r   <= '0;
      prefix_r <= '0;
      runlen_r <= '0;
      tstart_r <= '0;
      pos_r    <= '0;
      line_r   <= LINE_BITS'(1);
    end else if (accept) begin
      mode_r   <= mode_nxt;
      pend_r   <= pend_nxt;
      prefix_r <= prefix_nxt;
      runlen_r <= runlen_nxt;
      tstart_r <= tstart_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
    end
  end

endmodule

### rtl/stu_queue.sv
`timescale 1ns / 1ps

module stu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  stu_pkg::bundle_t  push_data,
  input  logic              pop,
  output stu_pkg::bundle_t  head,
  output stu_pkg::q_stat_t  q_stat
);
  import stu_pkg::*;

  bundle_t               mem_r [QDEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_BITS:0]    cnt_r, cnt_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign q_stat.full  = (cnt_r == (QPTR_BITS + 1)'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### rtl/stu_back.sv
`timescale 1ns / 1ps

module stu_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  stu_pkg::bundle_t                   head,
  input  stu_pkg::q_stat_t                   q_stat,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [stu_pkg::KIND_BITS-1:0]      out_token_kind,
  output logic [stu_pkg::LINE_BITS-1:0]      out_line_number,
  output logic [stu_pkg::OFFSET_BITS-1:0]    out_start_offset,
  output logic [stu_pkg::LENGTH_BITS-1:0]    out_token_length,
  output logic                               out_run_last
);
  import stu_pkg::*;

  logic [CNT_BITS-1:0] idx_r, idx_nxt;
  tok_t                sel;
  logic                fire;

  assign out_valid        = !q_stat.empty;
  assign sel              = head.tok[idx_r];
  assign out_token_kind   = sel.kind;
  assign out_line_number  = sel.line;
  assign out_start_offset = sel.start;
  assign out_token_length = sel.len;
  assign out_run_last     = (idx_r == CNT_BITS'(head.cnt - 1'b1));
  assign fire             = out_valid && !out_stall;
  assign pop              = fire && out_run_last;

  always_comb begin
    idx_nxt = idx_r;
    if (fire) begin
      idx_nxt = out_run_last ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

### rtl/source_text_tokenizer_unit.sv
`timescale 1ns / 1ps
// Accepted bytes push their tokens into the bundle queue, and the output reads them from its head.
// One byte per cycle while each byte raises at most one token and the output is not stalled;
// the n tokens of one byte leave in turn on the single output channel, a four-bundle queue absorbing them.
// Reset (synchronous, active low): scanner idle, line 1, offset 0, queue empty.
// The scanner also returns to that state after each byte marked as last.

module source_text_tokenizer_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_char_byte,
  input  logic                               in_end_of_source,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [stu_pkg::KIND_BITS-1:0]      out_token_kind,
  output logic [stu_pkg::LINE_BITS-1:0]      out_line_number,
  output logic [stu_pkg::OFFSET_BITS-1:0]    out_start_offset,
  output logic [stu_pkg::LENGTH_BITS-1:0]    out_token_length,
  output logic                               out_run_last
);
  import stu_pkg::*;

  q_stat_t q_stat;
  bundle_t push_data;
  bundle_t head;
  logic    push;
  logic    pop;

  stu_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .in_end_of_source (in_end_of_source),
    .q_stat           (q_stat),
    .push             (push),
    .push_data        (push_data)
  );

  stu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  stu_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_stat           (q_stat),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_line_number  (out_line_number),
    .out_start_offset (out_start_offset),
    .out_token_length (out_token_length),
    .out_run_last     (out_run_last)
  );

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

  import stu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES = 185;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;

  typedef enum logic [2:0] {
    SC_IDLE, SC_NUM, SC_WORD, SC_SYM, SC_COMMENT, SC_ERROR, SC_DONE
  } scan_e;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } src_word_t;

  typedef struct {
    logic [KIND_BITS-1:0]   kind;
    logic [LINE_BITS-1:0]   line;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] len;
    logic                   last;
  } token_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_char_byte = 8'h00;
  logic in_end_of_source = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [KIND_BITS-1:0] out_token_kind;
  logic [LINE_BITS-1:0] out_line_number;
  logic [OFFSET_BITS-1:0] out_start_offset;
  logic [LENGTH_BITS-1:0] out_token_length;
  logic out_run_last;

  source_text_tokenizer_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .in_end_of_source (in_end_of_source),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_line_number  (out_line_number),
    .out_start_offset (out_start_offset),
    .out_token_length (out_token_length),
    .out_run_last     (out_run_last)
  );

  always #10 clk = ~clk;

  src_word_t byte_queue[$];
  token_t    pending_tokens[$];
  logic [7:0] src[$];

  int unsigned cycles = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int sources = 0;
  int tokens_checked = 0;
  logic [31:0] kinds_seen = '0;
  bit quiet = 1'b0;
  int src_gap = 0;
  int sink_gap = 0;
  src_word_t next_word;
  token_t want;

  // scanner shadow state
  scan_e                  sc_mode;
  logic [7:0]             held_sym;
  logic [39:0]            word_pfx;
  logic [LENGTH_BITS-1:0] run_len;
  logic [OFFSET_BITS-1:0] tok_start;
  logic [OFFSET_BITS-1:0] next_pos;
  logic [LINE_BITS-1:0]   cur_line;
  int                     byte_tokens;

  function automatic logic [OFFSET_BITS-1:0] bump_off(logic [OFFSET_BITS-1:0] x);
    return (&x) ? x : x + 1'b1;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] bump_len(logic [LENGTH_BITS-1:0] x);
    return (&x) ? x : x + 1'b1;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [KIND_BITS-1:0] word_kind(logic [39:0] pfx,
                                                     logic [LENGTH_BITS-1:0] len);
    if (len == 3 && pfx == "let") return K_LET;
    if (len == 4 && pfx == "null") return K_NULL;
    if (len == 5 && pfx == "print") return K_PRINT;
    if (len == 2 && pfx == "if") return K_IF;
    if (len == 4 && pfx == "true") return K_TRUE;
    if (len == 5 && pfx == "false") return K_FALSE;
    if (len == 4 && pfx == "else") return K_ELSE;
    if (len == 5 && pfx == "while") return K_WHILE;
    if (len == 3 && pfx == "for") return K_FOR;
    return K_IDENT;
  endfunction

  function automatic logic [KIND_BITS-1:0] single_kind(logic [7:0] c);
    case (c)
      "=": return K_ASSIGN;
      "+": return K_PLUS;
      "-": return K_MINUS;
      "*": return K_STAR;
      "/": return K_SLASH;
      ";": return K_SEMI;
      "(": return K_LPAREN;
      ")": return K_RPAREN;
      "{": return K_LBRACE;
      "}": return K_RBRACE;
      "!": return K_BANG;
      ">": return K_GT;
      "<": return K_LT;
      default: return K_ERROR;
    endcase
  endfunction

  task automatic reset_scanner();
    sc_mode   = SC_IDLE;
    held_sym  = '0;
    word_pfx  = '0;
    run_len   = '0;
    tok_start = '0;
    next_pos  = '0;
    cur_line  = 1;
  endtask

  task automatic emit_token(logic [KIND_BITS-1:0] kind, logic [OFFSET_BITS-1:0] start,
                            logic [LENGTH_BITS-1:0] len);
    token_t t;
    if (byte_tokens < MAX_RES) begin
      t.kind  = kind;
      t.line  = cur_line;
      t.start = start;
      t.len   = len;
      t.last  = 1'b0;
      pending_tokens.insert(pending_tokens.size(), t);
      byte_tokens++;
    end
  endtask

  task automatic close_pending_token();
    logic [KIND_BITS-1:0] k;
    case (sc_mode)
      SC_NUM: begin
        emit_token(K_NUMBER, tok_start, run_len);
        sc_mode = SC_IDLE;
      end
      SC_WORD: begin
        emit_token(word_kind(word_pfx, run_len), tok_start, run_len);
        sc_mode = SC_IDLE;
      end
      SC_SYM: begin
        k = single_kind(held_sym);
        emit_token(k, tok_start, 1);
        sc_mode = (k == K_ERROR) ? SC_ERROR : SC_IDLE;
      end
      default: ;
    endcase
  endtask

  task automatic tokenize_byte(logic [7:0] c, logic last);
    logic [OFFSET_BITS-1:0] pos;
    logic [KIND_BITS-1:0] k;
    bit used;
    pos = next_pos;
    used = 1'b0;
    byte_tokens = 0;
    if (sc_mode == SC_DONE) begin
      if (last) reset_scanner();
    end else if (sc_mode == SC_ERROR) begin
      if (last) begin
        emit_token(K_EOF, bump_off(pos), 0);
        reset_scanner();
      end
    end else begin
      if (sc_mode == SC_NUM && is_digit(c)) begin
        run_len = bump_len(run_len);
        used = 1'b1;
      end else if (sc_mode == SC_WORD && (is_digit(c) || is_alpha(c) || c == "_")) begin
        if (run_len < 5) word_pfx = {word_pfx[31:0], c};
        run_len = bump_len(run_len);
        used = 1'b1;
      end else if (sc_mode == SC_SYM) begin
        used = 1'b1;
        if (held_sym == "/" && c == "/") begin
          sc_mode = SC_COMMENT;
        end else if (c == "=" && (held_sym == "=" || held_sym == ">" || held_sym == "<")) begin
          emit_token(held_sym == "=" ? K_EQ : (held_sym == ">" ? K_GE : K_LE), tok_start, 2);
          sc_mode = SC_IDLE;
        end else if ((held_sym == "|" || held_sym == "&") && c == held_sym) begin
          emit_token(held_sym == "|" ? K_OROR : K_ANDAND, tok_start, 2);
          sc_mode = SC_IDLE;
        end else begin
          used = 1'b0;
          close_pending_token();
          // lone | or & swallows the byte after it
          if (sc_mode == SC_ERROR) used = 1'b1;
        end
      end else if (sc_mode == SC_COMMENT) begin
        if (c == CH_LF || c == CH_NUL) sc_mode = SC_IDLE;
        else used = 1'b1;
      end else begin
        close_pending_token();
      end

      if (!used && sc_mode == SC_IDLE) begin
        if (c == CH_NUL) begin
          emit_token(K_EOF, pos, 0);
          sc_mode = SC_DONE;
        end else if (is_digit(c)) begin
          sc_mode = SC_NUM;
          tok_start = pos;
          run_len = 1;
        end else if (is_alpha(c)) begin
          sc_mode = SC_WORD;
          tok_start = pos;
          run_len = 1;
          word_pfx = {32'h0, c};
        end else if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
          if (c == CH_LF && !(&cur_line)) cur_line = cur_line + 1'b1;
        end else if (c == "=" || c == ">" || c == "<" || c == "/" || c == "|" || c == "&") begin
          sc_mode = SC_SYM;
          held_sym = c;
          tok_start = pos;
        end else begin
          k = single_kind(c);
          emit_token(k, pos, 1);
          if (k == K_ERROR) sc_mode = SC_ERROR;
        end
      end

      next_pos = bump_off(pos);

      if (last) begin
        close_pending_token();
        if (sc_mode != SC_DONE) emit_token(K_EOF, next_pos, 0);
        reset_scanner();
      end
    end
    if (byte_tokens > 0) pending_tokens[pending_tokens.size() - 1].last = 1'b1;
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // source text builders
  task automatic add_byte(logic [7:0] b);
    src.insert(src.size(), b);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic close_source();
    src_word_t w;
    for (int i = 0; i < src.size(); i++) begin
      w.ch = src[i];
      w.last = (i == src.size() - 1);
      byte_queue.insert(byte_queue.size(), w);
    end
    src.delete();
    sources++;
  endtask

  function automatic string keyword_text(int i);
    case (i)
      0: return "let";
      1: return "null";
      2: return "print";
      3: return "if";
      4: return "true";
      5: return "false";
      6: return "else";
      7: return "while";
      default: return "for";
    endcase
  endfunction

  function automatic string op_text(int i);
    case (i)
      0: return "=";
      1: return "==";
      2: return "+";
      3: return "-";
      4: return "*";
      5: return "/";
      6: return ";";
      7: return "(";
      8: return ")";
      9: return "{";
      10: return "}";
      11: return "!";
      12: return ">";
      13: return ">=";
      14: return "<";
      15: return "<=";
      16: return "||";
      default: return "&&";
    endcase
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(0, 5))
      0: return " ";
      1: return 8'd9;
      2: return CH_LF;
      3: return 8'd11;
      4: return 8'd12;
      default: return 8'd13;
    endcase
  endfunction

  task automatic gen_source();
    int parts;
    int n;
    parts = $urandom_range(2, 10);
    for (int p = 0; p < parts; p++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
          repeat (n) add_byte(8'($urandom_range("0", "9")));
        end
        2, 3: begin
          if ($urandom_range(0, 1)) begin
            add_text(keyword_text($urandom_range(0, 8)));
            if ($urandom_range(0, 3) == 0) add_byte(rand_letter());
          end else begin
            add_byte(rand_letter());
            repeat ($urandom_range(0, 6)) begin
              case ($urandom_range(0, 3))
                0, 1: add_byte(rand_letter());
                2: add_byte(8'($urandom_range("0", "9")));
                default: add_byte("_");
              endcase
            end
          end
        end
        4, 5, 6: add_text(op_text($urandom_range(0, 17)));
        7: repeat ($urandom_range(1, 3)) add_byte(rand_space());
        8: begin
          add_text("//");
          repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(32, 126)));
          if ($urandom_range(0, 3) != 0) add_byte(CH_LF);
        end
        default: add_byte(" ");
      endcase
      if ($urandom_range(0, 1)) add_byte($urandom_range(0, 2) ? " " : CH_LF);
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 5))
          0: add_byte(8'($urandom_range(0, 255)));
          1: add_byte("|");
          2: add_byte("&");
          3: add_byte("_");
          4: add_byte(CH_NUL);
          default: add_byte(8'($urandom_range(128, 255)));
        endcase
      end
    end
    close_source();
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        tokenize_byte(in_char_byte, in_end_of_source);
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && cycles[6] && $urandom_range(0, 4) == 0) begin
          src_gap = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          next_word = byte_queue.pop_front();
          in_valid <= 1'b1;
          in_char_byte <= next_word.ch;
          in_end_of_source <= next_word.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_tokens.size() == 0) begin
          report_mismatch($sformatf("unexpected token kind %0d at offset %0d",
                                    out_token_kind, out_start_offset));
        end else begin
          want = pending_tokens.pop_front();
          if (out_token_kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d (offset %0d)",
                                      out_token_kind, want.kind, want.start));
          if (out_line_number !== want.line)
            report_mismatch($sformatf("line %0d, want %0d (offset %0d)",
                                      out_line_number, want.line, want.start));
          if (out_start_offset !== want.start)
            report_mismatch($sformatf("offset %0d, want %0d",
                                      out_start_offset, want.start));
          if (out_token_length !== want.len)
            report_mismatch($sformatf("length %0d, want %0d (offset %0d)",
                                      out_token_length, want.len, want.start));
          if (out_run_last !== want.last)
            report_mismatch($sformatf("run_last %0b, want %0b (offset %0d)",
                                      out_run_last, want.last, want.start));
          kinds_seen[out_token_kind] = 1'b1;
          tokens_checked++;
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && (cycles[5] ^ cycles[7]) && $urandom_range(0, 3) == 0) begin
        sink_gap = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout: %0d tokens still expected", pending_tokens.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int directed_n;
    reset_scanner();

    // held >= then comment, lone | on the last word
    add_text("v>=12//c\n|");
    close_source();
    // lone & eats the next word, rest dropped until last
    add_text("&x_");
    add_byte(8'hFF);
    add_text("q");
    close_source();
    // underscore error and eof from one word
    add_text("_");
    close_source();
    // NUL flushes the word, later words dropped
    add_text("ab");
    add_byte(CH_NUL);
    add_text("z");
    close_source();
    add_byte(CH_NUL);
    close_source();
    // three tokens from the last word
    add_text("a=+");
    close_source();
    directed_n = byte_queue.size();

    while (byte_queue.size() < directed_n + RANDOM_BYTES) gen_source();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_queue.size() > 40) @(negedge clk);
    quiet = 1'b1;
    while (byte_queue.size() > 0 || in_valid) @(negedge clk);
    while (pending_tokens.size() > 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("%0d bytes in %0d sources sent, %0d tokens checked, %0d of 31 kinds seen",
             bytes_sent, sources, tokens_checked, $countones(kinds_seen));
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/stu_pkg.sv
rtl/stu_front.sv
rtl/stu_queue.sv
rtl/stu_back.sv
rtl/source_text_tokenizer_unit.sv
dv/tb.sv
